[rtl/toif_pkg.sv]
`timescale 1ns / 1ps

package toif_pkg;

	// sample and coefficient formats
	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_FRAC_BITS = 27;
	localparam int STATE_FRAC     = 16;
	localparam int COEF_BITS      = 32;
	localparam int ACC_BITS       = 48;

	// datapath widths
	localparam int PART_BITS = ACC_BITS / 2;
	localparam int MUL_BITS  = COEF_BITS + PART_BITS;
	localparam int MAG_BITS  = COEF_BITS + ACC_BITS;
	localparam int RND_BITS  = MAG_BITS + 1;
	localparam int CAP_LOG2  = 58;
	localparam int TERM_BITS = CAP_LOG2 + 1;
	localparam int SUM_BITS  = TERM_BITS + 3;
	localparam int Q_BITS    = ACC_BITS + 1 - STATE_FRAC;
	localparam int SHIFT_X   = COEF_FRAC_BITS - STATE_FRAC;
	localparam int SHIFT_Y   = COEF_FRAC_BITS;

	// coefficient store
	localparam int NUM_COEF      = 7;
	localparam int NUM_FF        = 4;
	localparam int CFG_IDX_BITS  = 3;
	localparam int COEF_SEL_BITS = 3;
	localparam int DEST_BITS     = 2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_B0 = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_B1 = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] CFG_B2 = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] CFG_B3 = CFG_IDX_BITS'(3);
	localparam logic [CFG_IDX_BITS-1:0] CFG_A1 = CFG_IDX_BITS'(4);
	localparam logic [CFG_IDX_BITS-1:0] CFG_A2 = CFG_IDX_BITS'(5);
	localparam logic [CFG_IDX_BITS-1:0] CFG_A3 = CFG_IDX_BITS'(6);

	localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

	// sum targets of a product term
	localparam logic [DEST_BITS-1:0] DEST_Y  = 2'd0;
	localparam logic [DEST_BITS-1:0] DEST_N1 = 2'd1;
	localparam logic [DEST_BITS-1:0] DEST_N2 = 2'd2;
	localparam logic [DEST_BITS-1:0] DEST_N3 = 2'd3;

	// sequencing: two multiplier passes per coefficient, three stages behind issue
	localparam int NUM_PASS    = 2 * NUM_COEF;
	localparam int PIPE_DEPTH  = 3;
	localparam int LAST_STEP   = NUM_PASS - 1 + PIPE_DEPTH;
	localparam int STEP_BITS   = $clog2(LAST_STEP + 1);
	localparam int Y_LOAD_STEP = 1 + PIPE_DEPTH + 1;
	localparam int Y_ABS_STEP  = Y_LOAD_STEP + 1;

	localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
	localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef struct packed {
		logic                     valid;
		logic                     src_y;
		logic                     hi;
		logic                     sub;
		logic [COEF_SEL_BITS-1:0] coef_sel;
		logic [DEST_BITS-1:0]     dest;
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
		logic y_load;
		logic y_abs;
		logic commit;
	} cmd_t;

	function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [SUM_BITS-1:0] v);
		logic signed [SUM_BITS-1:0] hi_lim;
		logic signed [SUM_BITS-1:0] lo_lim;
		logic signed [ACC_BITS-1:0] res;
		hi_lim = SUM_BITS'(ACC_MAX);
		lo_lim = SUM_BITS'(ACC_MIN);
		if (v > hi_lim) begin
			res = ACC_MAX;
		end else if (v < lo_lim) begin
			res = ACC_MIN;
		end else begin
			res = v[ACC_BITS-1:0];
		end
		return res;
	endfunction

endpackage

[rtl/toif_ctrl.sv]
`timescale 1ns / 1ps

module toif_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output toif_pkg::cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]                        state_q;
	logic [toif_pkg::STEP_BITS-1:0]    step_q;
	logic                              out_valid_q;
	logic                              start;
	logic                              commit;
	logic                              issue;
	logic [toif_pkg::COEF_SEL_BITS-1:0] prod;
	logic                              fb;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign start     = in_valid && (state_q == ST_IDLE);
	assign commit    = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	// step -> product index and pass half
	assign issue = (state_q == ST_RUN) && (step_q < toif_pkg::STEP_BITS'(toif_pkg::NUM_PASS));
	assign prod  = toif_pkg::COEF_SEL_BITS'(step_q >> 1);
	assign fb    = (prod >= toif_pkg::COEF_SEL_BITS'(toif_pkg::NUM_FF));

	always_comb begin
		cmd              = '0;
		cmd.start        = start;
		cmd.op.valid     = issue;
		cmd.op.src_y     = fb;
		cmd.op.hi        = step_q[0];
		cmd.op.sub       = fb;
		cmd.op.coef_sel  = prod;
		cmd.op.dest      = fb ? toif_pkg::DEST_BITS'(prod - toif_pkg::COEF_SEL_BITS'(toif_pkg::NUM_FF - 1))
			: toif_pkg::DEST_BITS'(prod);
		cmd.y_load       = (state_q == ST_RUN) && (step_q == toif_pkg::STEP_BITS'(toif_pkg::Y_LOAD_STEP));
		cmd.y_abs        = (state_q == ST_RUN) && (step_q == toif_pkg::STEP_BITS'(toif_pkg::Y_ABS_STEP));
		cmd.commit       = commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					if (step_q == toif_pkg::STEP_BITS'(toif_pkg::LAST_STEP)) begin
						state_q <= ST_FIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/toif_datapath.sv]
`timescale 1ns / 1ps

module toif_datapath (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  toif_pkg::cmd_t                            cmd,
	input  logic                                      cfg_wr_en,
	input  logic [toif_pkg::CFG_IDX_BITS-1:0]         cfg_index,
	input  logic [toif_pkg::COEF_BITS-1:0]            cfg_wr_data,
	input  logic signed [toif_pkg::SAMPLE_BITS-1:0]   sample_in,
	output logic signed [toif_pkg::SAMPLE_BITS-1:0]   sample_out,
	output logic                                      clipped
);

	localparam int AB = toif_pkg::ACC_BITS;
	localparam int SB = toif_pkg::SUM_BITS;
	localparam int RB = toif_pkg::RND_BITS;
	localparam int QB = toif_pkg::Q_BITS;

	localparam logic [RB-1:0] RND_X = (RB'(1) << toif_pkg::SHIFT_X) >> 1;
	localparam logic [RB-1:0] RND_Y = (RB'(1) << toif_pkg::SHIFT_Y) >> 1;
	localparam logic [RB-1:0] CAP   = RB'(1) << toif_pkg::CAP_LOG2;
	localparam logic [AB:0]   HALF  = (AB+1)'(1) << (toif_pkg::STATE_FRAC - 1);
	localparam logic signed [QB-1:0] Q_MAX = QB'(toif_pkg::SAMPLE_MAX);
	localparam logic signed [QB-1:0] Q_MIN = QB'(toif_pkg::SAMPLE_MIN);

	// coefficients kept as sign and magnitude
	logic [toif_pkg::COEF_BITS-1:0] coef_mag_q [toif_pkg::NUM_COEF];
	logic                           coef_neg_q [toif_pkg::NUM_COEF];

	logic [AB-1:0]        x_abs_q;
	logic                 x_neg_q;
	logic signed [AB-1:0] y_q;
	logic [AB-1:0]        y_abs_q;
	logic                 y_neg_q;
	logic signed [AB-1:0] acc1_q, acc2_q, acc3_q;
	logic signed [SB-1:0] ysum_q, n1sum_q, n2sum_q, n3sum_q;

	logic signed [AB-1:0] x_ext;
	logic [AB-1:0]        v_mag;
	logic                 v_neg;
	logic [toif_pkg::PART_BITS-1:0] part;

	toif_pkg::op_t                  op_s1, op_s2, op_s3;
	logic [toif_pkg::MUL_BITS-1:0]  mul_s1;
	logic                           neg_s1, neg_s2, neg_s3;
	logic [toif_pkg::MAG_BITS-1:0]  p_s2;
	logic [toif_pkg::TERM_BITS-1:0] r_s3;

	logic [RB-1:0]        rnd_t;
	logic [RB-1:0]        rnd_r;
	logic signed [SB-1:0] delta;
	logic signed [AB:0]   y_rnd;
	logic signed [QB-1:0] q_full;

	// config write; index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < toif_pkg::NUM_COEF; i++) begin
				coef_mag_q[i] <= (i == 0) ? toif_pkg::COEF_ONE : '0;
				coef_neg_q[i] <= 1'b0;
			end
		end else if (cfg_wr_en && (cfg_index <= toif_pkg::CFG_A3)) begin
			coef_neg_q[cfg_index] <= cfg_wr_data[toif_pkg::COEF_BITS-1];
			coef_mag_q[cfg_index] <= cfg_wr_data[toif_pkg::COEF_BITS-1] ? -cfg_wr_data
				: cfg_wr_data;
		end
	end

	assign x_ext = AB'(sample_in);
	assign v_mag = cmd.op.src_y ? y_abs_q : x_abs_q;
	assign v_neg = cmd.op.src_y ? y_neg_q : x_neg_q;
	assign part  = cmd.op.hi ? v_mag[AB-1:toif_pkg::PART_BITS] : v_mag[toif_pkg::PART_BITS-1:0];

	// rounding shift of the finished magnitude, sign of the capped term, output rounding
	always_comb begin
		rnd_t = RB'(p_s2) + (op_s2.src_y ? RND_Y : RND_X);
		rnd_r = op_s2.src_y ? (rnd_t >> toif_pkg::SHIFT_Y) : (rnd_t >> toif_pkg::SHIFT_X);
		delta = neg_s3 ? -SB'(r_s3) : SB'(r_s3);
		y_rnd = (AB+1)'(y_q) + HALF;
		q_full = QB'(y_rnd >>> toif_pkg::STATE_FRAC);
	end

	// multiplier pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
			op_s2 <= '0;
			op_s3 <= '0;
		end else begin
			op_s1 <= cmd.op;
			op_s2 <= op_s1;
			op_s3 <= op_s2;
		end
	end

	always_ff @(posedge clk) begin
		mul_s1 <= toif_pkg::MUL_BITS'(coef_mag_q[cmd.op.coef_sel])
			* toif_pkg::MUL_BITS'(part);
		neg_s1 <= v_neg ^ coef_neg_q[cmd.op.coef_sel] ^ cmd.op.sub;
		// high half lands on top of the low half issued just before
		p_s2   <= op_s1.hi ? p_s2 + (toif_pkg::MAG_BITS'(mul_s1) << toif_pkg::PART_BITS)
			: toif_pkg::MAG_BITS'(mul_s1);
		neg_s2 <= neg_s1;
		r_s3   <= (rnd_r > CAP) ? toif_pkg::TERM_BITS'(CAP) : toif_pkg::TERM_BITS'(rnd_r);
		neg_s3 <= neg_s2;
	end

	// operands, partial sums, outputs
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_neg_q <= x_ext[AB-1];
			x_abs_q <= x_ext[AB-1] ? -x_ext : x_ext;
			ysum_q  <= SB'(acc1_q);
			n1sum_q <= SB'(acc2_q);
			n2sum_q <= SB'(acc3_q);
			n3sum_q <= '0;
		end else if (op_s3.valid && op_s3.hi) begin
			case (op_s3.dest)
				toif_pkg::DEST_Y:  ysum_q  <= ysum_q + delta;
				toif_pkg::DEST_N1: n1sum_q <= n1sum_q + delta;
				toif_pkg::DEST_N2: n2sum_q <= n2sum_q + delta;
				default:           n3sum_q <= n3sum_q + delta;
			endcase
		end
		if (cmd.y_load) begin
			y_q <= toif_pkg::sat_acc(ysum_q);
		end
		if (cmd.y_abs) begin
			y_neg_q <= y_q[AB-1];
			y_abs_q <= y_q[AB-1] ? -y_q : y_q;
		end
		if (cmd.commit) begin
			if (q_full > Q_MAX) begin
				sample_out <= toif_pkg::SAMPLE_MAX;
				clipped    <= 1'b1;
			end else if (q_full < Q_MIN) begin
				sample_out <= toif_pkg::SAMPLE_MIN;
				clipped    <= 1'b1;
			end else begin
				sample_out <= q_full[toif_pkg::SAMPLE_BITS-1:0];
				clipped    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc1_q <= '0;
			acc2_q <= '0;
			acc3_q <= '0;
		end else if (cmd.commit) begin
			acc1_q <= toif_pkg::sat_acc(n1sum_q);
			acc2_q <= toif_pkg::sat_acc(n2sum_q);
			acc3_q <= toif_pkg::sat_acc(n3sum_q);
		end
	end

endmodule

[rtl/third_order_iir_tone_filter.sv]
// Third-order IIR tone filter, transposed direct form II, fixed point. Each
// input word (signed sample) gives one output word: the filtered sample rounded
// half up and saturated, with clipped set when saturation hit. Seven signed
// Q5.27 coefficients (b0..b3, a1..a3, indexes 0..6) are written through the
// plain write port; the user must write them only while the filter is idle,
// which the block itself does not enforce; a write to index 7 is dropped.
// Reset loads b0 = 1.0 (pass-through) and clears the other coefficients and
// the three 48-bit states (16 fractional bits). Datapath: one shared 32x24
// multiplier takes two passes per coefficient, 14 passes per sample, followed
// by a three-stage round/accumulate tail. A new word is taken only once the
// last one has been committed to the output side. The next input may be taken
// while a result still waits on the output.
`timescale 1ns / 1ps

module third_order_iir_tone_filter (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [toif_pkg::SAMPLE_BITS-1:0] sample_in,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [toif_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic                                    clipped,
	input  logic                                    cfg_wr_en,
	input  logic [toif_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [toif_pkg::COEF_BITS-1:0]          cfg_wr_data
);

	// commands from sequencer to datapath
	toif_pkg::cmd_t cmd;

	// sequencer: step counter walks b0..b3 on x, then a1..a3 on y
	toif_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// datapath: coefficient store, multiplier pipe, partial sums, states
	toif_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.sample_in   (sample_in),
		.sample_out  (sample_out),
		.clipped     (clipped)
	);

endmodule

[rtl/toif_checker.sv]
`timescale 1ns / 1ps

module toif_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_valid,
	input logic                                    in_stall,
	input logic                                    out_valid,
	input logic                                    out_stall,
	input logic signed [toif_pkg::SAMPLE_BITS-1:0] sample_out,
	input logic                                    clipped
);

	// one word in flight: busy right after a word is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a word was in flight");

	// no result can appear the cycle after taking a word
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result appeared one cycle after input");

	// clipped result must sit on a rail
	a_clip_on_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> sample_out == toif_pkg::SAMPLE_MAX
			|| sample_out == toif_pkg::SAMPLE_MIN)
		else $error("clipped set on a value inside range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(clipped))
		else $error("stalled output word changed");

endmodule

bind third_order_iir_tone_filter toif_checker u_toif_checker (.*);
